// ----- sv/qspid_pkg.sv -----
// shared types, constants, microcode table and rounding helper for the speed controller
package qspid_pkg;

  localparam int CNT_W      = 16;
  localparam int SPEED_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int ERR_W      = SPEED_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int MUL_A_W    = DIFF_W + 1;
  localparam int MUL_B_W    = GAIN_W + 1;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int Q_BITS     = 8;
  localparam int RZ_W       = MUL_P_W - Q_BITS;
  localparam int ACC_W      = RZ_W + 2;
  localparam int INTEG_W    = 20;
  localparam int DRIVE_W    = 11;
  localparam int PC_W       = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int INTEG_HIGH   = 1000 * 256;
  localparam int INTEG_RELOAD = 500 * 256;
  localparam int DRIVE_MAX    = 1024;
  localparam int DRIVE_LIMIT  = DRIVE_MAX * 256;

  localparam logic [SPEED_W-1:0] TARGET_RST = 32'd25600;
  localparam logic [GAIN_W-1:0]  PROP_RST   = 16'd2560;
  localparam logic [GAIN_W-1:0]  INTEG_RST  = 16'd256;
  localparam logic [GAIN_W-1:0]  DERIV_RST  = 16'd1280;
  localparam logic [GAIN_W-1:0]  SCALE_RST  = 16'd256;

  typedef enum logic [1:0] {
    FUNC_EDGE_A = 2'd0,
    FUNC_EDGE_B = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_PROP   = 3'd1,
    REG_INTEG  = 3'd2,
    REG_DERIV  = 3'd3,
    REG_SCALE  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MA_COUNT = 2'd0,
    MA_ERR   = 2'd1,
    MA_DIFF  = 2'd2
  } mul_a_t;

  typedef enum logic [1:0] {
    MB_SCALE = 2'd0,
    MB_PROP  = 2'd1,
    MB_INTEG = 2'd2,
    MB_DERIV = 2'd3
  } mul_b_t;

  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_ACCEPT = 4'd1,
    OP_SPEED  = 4'd2,
    OP_ERR    = 4'd3,
    OP_DIFF   = 4'd4,
    OP_ACC_P  = 4'd5,
    OP_INTEG  = 4'd6,
    OP_ADD_I  = 4'd7,
    OP_ADD_D  = 4'd8,
    OP_EMIT   = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT     = 2'd0,
    SEQ_WAIT_IN  = 2'd1,
    SEQ_WAIT_OUT = 2'd2
  } seq_t;

  typedef struct packed {
    op_t             op;
    logic            mul_en;
    mul_a_t          mul_a;
    mul_b_t          mul_b;
    seq_t            seq;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic go_tick;
    logic out_free;
  } stat_t;

  // microprogram: step 0 takes items, steps 1 to 9 run one tick
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{op: OP_NOP, mul_en: 1'b0, mul_a: MA_COUNT, mul_b: MB_SCALE,
          seq: SEQ_NEXT, target: '0};
    unique case (pc)
      4'd0: begin
        c.op  = OP_ACCEPT;
        c.seq = SEQ_WAIT_IN;
      end
      4'd1: begin
        c.mul_en = 1'b1;
        c.mul_a  = MA_COUNT;
        c.mul_b  = MB_SCALE;
      end
      4'd2: c.op = OP_SPEED;
      4'd3: c.op = OP_ERR;
      4'd4: begin
        c.op     = OP_DIFF;
        c.mul_en = 1'b1;
        c.mul_a  = MA_ERR;
        c.mul_b  = MB_PROP;
      end
      4'd5: begin
        c.op     = OP_ACC_P;
        c.mul_en = 1'b1;
        c.mul_a  = MA_ERR;
        c.mul_b  = MB_INTEG;
      end
      4'd6: begin
        c.op     = OP_INTEG;
        c.mul_en = 1'b1;
        c.mul_a  = MA_DIFF;
        c.mul_b  = MB_DERIV;
      end
      4'd7: c.op = OP_ADD_I;
      4'd8: c.op = OP_ADD_D;
      4'd9: begin
        c.op     = OP_EMIT;
        c.seq    = SEQ_WAIT_OUT;
        c.target = '0;
      end
      default: begin
        c.seq    = SEQ_WAIT_OUT;
        c.target = '0;
      end
    endcase
    return c;
  endfunction

  // divide a product by 256, rounding toward zero
  function automatic logic signed [RZ_W-1:0] rz(logic signed [MUL_P_W-1:0] x);
    logic signed [MUL_P_W-1:0] t;
    t = x + (x[MUL_P_W-1] ? {{(MUL_P_W-Q_BITS){1'b0}}, {Q_BITS{1'b1}}} : '0);
    return t[MUL_P_W-1:Q_BITS];
  endfunction

endpackage

// ----- sv/qspid_seq.sv -----
// microcode sequencer: step counter, control word lookup and jumps
module qspid_seq import qspid_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;

  assign ctrl = ucode(pc_r);

  always_comb begin
    pc_nxt = pc_r;
    unique case (ctrl.seq)
      SEQ_NEXT:     pc_nxt = PC_W'(pc_r + 1'b1);
      SEQ_WAIT_IN:  pc_nxt = stat.go_tick ? PC_W'(pc_r + 1'b1) : pc_r;
      SEQ_WAIT_OUT: pc_nxt = stat.out_free ? ctrl.target : pc_r;
      default:      pc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- sv/qspid_dp.sv -----
// datapath: edge counter, config registers, shared multiplier, pid accumulator, output register
module qspid_dp import qspid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_t                 ctrl,
  output stat_t                 stat,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic signed [RZ_W:0]    I_HIGH   = (RZ_W+1)'(INTEG_HIGH);
  localparam logic signed [RZ_W:0]    I_LOW    = (RZ_W+1)'(-INTEG_HIGH);
  localparam logic signed [INTEG_W-1:0] I_RELOAD_P = INTEG_W'(INTEG_RELOAD);
  localparam logic signed [INTEG_W-1:0] I_RELOAD_N = INTEG_W'(-INTEG_RELOAD);
  localparam logic signed [ACC_W-1:0] K_LIMIT  = ACC_W'(DRIVE_LIMIT);

  logic [SPEED_W-1:0]         target_r;
  logic [GAIN_W-1:0]          prop_r;
  logic [GAIN_W-1:0]          integ_r;
  logic [GAIN_W-1:0]          deriv_r;
  logic [GAIN_W-1:0]          scale_r;

  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           cnt_lat_r;
  logic signed [SPEED_W-1:0]  speed_r;
  logic signed [ERR_W-1:0]    err_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [MUL_P_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [INTEG_W-1:0]  i_r;
  logic signed [INTEG_W-1:0]  isum_r;
  logic signed [ERR_W-1:0]    last_err_r;

  logic                       out_valid_r;
  logic [DRIVE_W-1:0]         out_drive_r;
  logic [SPEED_W-1:0]         out_speed_r;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [RZ_W-1:0]     rz_v;
  logic signed [RZ_W:0]       i_sum;
  logic signed [INTEG_W-1:0]  i_nxt;
  logic [DRIVE_W-1:0]         drive_nxt;
  logic                       in_fire;
  func_t                      func;

  assign func      = func_t'(in_tuser);
  assign in_tready = (ctrl.op == OP_ACCEPT);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign stat.go_tick  = in_fire && (func == FUNC_TICK);
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_speed_r, out_drive_r};

  always_comb begin
    unique case (ctrl.mul_a)
      MA_COUNT: mul_a = {{(MUL_A_W-CNT_W){cnt_lat_r[CNT_W-1]}}, cnt_lat_r};
      MA_ERR:   mul_a = {{(MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
      MA_DIFF:  mul_a = {{(MUL_A_W-DIFF_W){diff_r[DIFF_W-1]}}, diff_r};
      default:  mul_a = '0;
    endcase
    unique case (ctrl.mul_b)
      MB_SCALE: mul_b = {1'b0, scale_r};
      MB_PROP:  mul_b = {1'b0, prop_r};
      MB_INTEG: mul_b = {1'b0, integ_r};
      MB_DERIV: mul_b = {1'b0, deriv_r};
      default:  mul_b = '0;
    endcase
  end

  assign rz_v  = rz(prod_r);
  assign i_sum = {{(RZ_W+1-INTEG_W){isum_r[INTEG_W-1]}}, isum_r} + {rz_v[RZ_W-1], rz_v};

  // integral reload past the limits
  always_comb begin
    priority if (i_sum > I_HIGH) begin
      i_nxt = I_RELOAD_P;
    end else if (i_sum < I_LOW) begin
      i_nxt = I_RELOAD_N;
    end else begin
      i_nxt = i_sum[INTEG_W-1:0];
    end
  end

  always_comb begin
    priority if (acc_r > K_LIMIT) begin
      drive_nxt = DRIVE_W'(DRIVE_MAX);
    end else if (acc_r[ACC_W-1]) begin
      drive_nxt = '0;
    end else begin
      drive_nxt = acc_r[Q_BITS+DRIVE_W-1:Q_BITS];
    end
  end

  // config and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= TARGET_RST;
      prop_r     <= PROP_RST;
      integ_r    <= INTEG_RST;
      deriv_r    <= DERIV_RST;
      scale_r    <= SCALE_RST;
      cnt_r      <= '0;
      isum_r     <= '0;
      last_err_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_TARGET: target_r <= cfg_data;
          REG_PROP:   prop_r   <= cfg_data[GAIN_W-1:0];
          REG_INTEG:  integ_r  <= cfg_data[GAIN_W-1:0];
          REG_DERIV:  deriv_r  <= cfg_data[GAIN_W-1:0];
          REG_SCALE:  scale_r  <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        unique case (func)
          FUNC_EDGE_A: cnt_r <= in_tdata[0] ? CNT_W'(cnt_r + 1'b1) : CNT_W'(cnt_r - 1'b1);
          FUNC_EDGE_B: cnt_r <= in_tdata[0] ? CNT_W'(cnt_r - 1'b1) : CNT_W'(cnt_r + 1'b1);
          FUNC_TICK:   cnt_r <= '0;
          default: ;
        endcase
      end
      if (ctrl.op == OP_ADD_D) begin
        isum_r     <= i_r;
        last_err_r <= err_r;
      end
    end
  end

  // working registers of one tick
  always_ff @(posedge clk) begin
    if (stat.go_tick) begin
      cnt_lat_r <= cnt_r;
    end
    if (ctrl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    unique case (ctrl.op)
      OP_SPEED: speed_r <= rz_v[SPEED_W-1:0];
      OP_ERR:   err_r   <= {target_r[SPEED_W-1], target_r} - {speed_r[SPEED_W-1], speed_r};
      OP_DIFF:  diff_r  <= {err_r[ERR_W-1], err_r} - {last_err_r[ERR_W-1], last_err_r};
      OP_ACC_P: acc_r   <= {{(ACC_W-RZ_W){rz_v[RZ_W-1]}}, rz_v};
      OP_INTEG: i_r     <= i_nxt;
      OP_ADD_I: acc_r   <= acc_r + {{(ACC_W-INTEG_W){i_r[INTEG_W-1]}}, i_r};
      OP_ADD_D: acc_r   <= acc_r + {{(ACC_W-RZ_W){rz_v[RZ_W-1]}}, rz_v};
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == OP_EMIT && stat.out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && stat.out_free) begin
      out_drive_r <= drive_nxt;
      out_speed_r <= speed_r;
    end
  end

endmodule

// ----- sv/quadrature_speed_pid.sv -----
// top level of the quadrature encoder speed controller with pid drive output
//
//  channel | dir | fields
//  in_     | in  | tuser[1:0] func, tdata[0] other_level
//  out_    | out | tdata[10:0] drive, tdata[42:11] measured_speed
//  cfg_    | in  | cfg_index register, cfg_data value
//
// an edge transfer is taken in step 0 and leaves the sequencer there; a tick runs the
// microprogram, which shares one 35x17 multiplier over four products
// reset clears counter, integral and last error and loads register defaults
// the last step waits while the output register still holds an untaken result
// the next input is taken while a result waits on the output
module quadrature_speed_pid import qspid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // other_level
  input  logic [1:0]            in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // drive, measured_speed
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_t ctrl;
  stat_t stat;

  qspid_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  qspid_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule
